// ===== rtl/core/sliding_window_max_count_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window max count: assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_COUNT_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAX_COUNT_CORE_DEFINES_SVH

// Checked only out of reset.
`define SWMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, in reset too.
`define SWMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/swmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window max count: package
// Widths, cell control bundle and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package swmc_pkg;

  localparam int TIME_W    = 32;
  localparam int CNT_W     = 11;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  typedef struct packed {
    logic clear;
    logic shift;
    logic push;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/sliding_window_max_count_core.sv =====
// ----------------------------------------------------------------------------
// Sliding window max count: top level
// Counts events inside a sliding time window and tracks the run maximum.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata = event_time, tuser = start_of_run
// m_axis    out  tdata = window_count, max_count, overflow
// cfg       in   cfg_wdata_i = window_seconds (written when cfg_we_i)
//
// An event is accepted in ST_IDLE; ST_PROC pops every entry aged out of the
// window, then pushes the event. Pops are bounded by pushes; no new event in ST_PROC.
// The queue is a row of FIFO_DEPTH cells, the oldest entry in cell 0.
// Reset empties the queue at once; start_of_run clears it as its event is taken.
// A pending result stalls the push step and with it the next input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_count_core #(
  parameter int FIFO_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [swmc_pkg::TIME_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [swmc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [31:0] event_time
  input  logic                               s_axis_tuser,  // [0] start_of_run
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [10:0] window_count, [21:11] max_count, [22] overflow, [23] zero
  output logic [swmc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int OW = swmc_pkg::CNT_W;
  localparam int TW = swmc_pkg::TIME_W;

  swmc_pkg::state_e     state_q, state_d;
  swmc_pkg::cell_ctrl_t ctrl;

  logic [TW-1:0] window_q;
  logic [TW-1:0] t_q;
  logic          load_t;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] best_q, best_d;
  logic          m_valid_q, m_valid_d;
  logic [swmc_pkg::M_TDATA_W-1:0] out_q, out_d;

  logic          c_valid [FIFO_DEPTH];
  logic [TW-1:0] c_time  [FIFO_DEPTH];

  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic          prev_v;
    logic          nb_v;
    logic [TW-1:0] nb_t;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = c_valid[i-1];
    end
    if (i == FIFO_DEPTH - 1) begin : g_last
      assign nb_v = 1'b0;
      assign nb_t = '0;
    end else begin : g_inner
      assign nb_v = c_valid[i+1];
      assign nb_t = c_time[i+1];
    end
    swmc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_time_i   (t_q),
      .prev_valid_i (prev_v),
      .nb_valid_i   (nb_v),
      .nb_time_i    (nb_t),
      .valid_o      (c_valid[i]),
      .time_o       (c_time[i])
    );
  end

  logic          older_ok;
  logic [TW-1:0] span;
  logic          pop_needed;
  logic          full;
  logic          out_free;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] best_new;
  logic [CW+OW-1:0] cnt_ext, best_ext;

  assign older_ok   = t_q >= c_time[0];
  assign span       = older_ok ? (t_q - c_time[0]) : '0;
  assign pop_needed = c_valid[0] && (span > window_q);
  assign full       = count_q == CW'(FIFO_DEPTH);
  assign out_free   = !m_valid_q || m_axis_tready;
  assign cnt_new    = full ? count_q : count_q + CW'(1);
  assign best_new   = (cnt_new > best_q) ? cnt_new : best_q;
  assign cnt_ext    = {{OW{1'b0}}, cnt_new};
  assign best_ext   = {{OW{1'b0}}, best_new};

  always_comb begin
    state_d   = state_q;
    ctrl      = '0;
    load_t    = 1'b0;
    count_d   = count_q;
    best_d    = best_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_d     = out_q;
    unique case (state_q)
      swmc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          load_t  = 1'b1;
          state_d = swmc_pkg::ST_PROC;
          if (s_axis_tuser) begin
            ctrl.clear = 1'b1;
            count_d    = '0;
            best_d     = '0;
          end
        end
      end
      swmc_pkg::ST_PROC: begin
        if (pop_needed) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - CW'(1);
        end else if (out_free) begin
          ctrl.push  = 1'b1;
          ctrl.shift = full;
          count_d    = cnt_new;
          best_d     = best_new;
          m_valid_d  = 1'b1;
          out_d      = {1'b0, full, best_ext[OW-1:0], cnt_ext[OW-1:0]};
          state_d    = swmc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swmc_pkg::ST_IDLE;
      window_q  <= TW'(60);
      count_q   <= '0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      best_q    <= best_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_t) begin
      t_q <= s_axis_tdata;
    end
  end

  assign s_axis_tready = state_q == swmc_pkg::ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/swmc_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window max count: window cell
// One slot of the timestamp queue; shifts toward the head on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module swmc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swmc_pkg::cell_ctrl_t             ctrl_i,
  input  logic [swmc_pkg::TIME_W-1:0]      new_time_i,
  input  logic                             prev_valid_i,
  input  logic                             nb_valid_i,
  input  logic [swmc_pkg::TIME_W-1:0]      nb_time_i,
  output logic                             valid_o,
  output logic [swmc_pkg::TIME_W-1:0]      time_o
);

  logic                        valid_q, valid_d;
  logic [swmc_pkg::TIME_W-1:0] time_q, time_d;

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      // last occupied slot takes the new beat when pop and push coincide
      if (ctrl_i.push && valid_q && !nb_valid_i) begin
        valid_d = 1'b1;
        time_d  = new_time_i;
      end else begin
        valid_d = nb_valid_i;
        time_d  = nb_time_i;
      end
    end else if (ctrl_i.push && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      time_d  = new_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;

endmodule

`default_nettype wire

// ===== rtl/core/swmc_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window max count: port checker
// Checks result beats seen on the output port over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_max_count_core_defines.svh"

module swmc_checker #(
  parameter int FIFO_DEPTH = 1024
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [swmc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int OW = swmc_pkg::CNT_W;
  localparam logic [OW-1:0] DEPTH_LOW = OW'(FIFO_DEPTH % (1 << OW));
  localparam logic WIDE = FIFO_DEPTH > ((1 << OW) - 1);

  logic [OW-1:0] win_cnt;
  logic [OW-1:0] max_cnt;
  logic          ovf;

  assign win_cnt = m_axis_tdata[OW-1:0];
  assign max_cnt = m_axis_tdata[2*OW-1:OW];
  assign ovf     = m_axis_tdata[2*OW];

  `SWMC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `SWMC_ASSERT(a_cnt_le_max, clk_i, rst_ni, m_axis_tvalid && !WIDE |-> win_cnt <= max_cnt && win_cnt != '0, "window count above maximum or zero")
  `SWMC_ASSERT(a_ovf_full, clk_i, rst_ni, m_axis_tvalid && ovf |-> win_cnt == DEPTH_LOW, "overflow without a full window")
  `SWMC_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !m_axis_tvalid, "result beat during reset")

endmodule

bind sliding_window_max_count_core swmc_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_swmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window max count: testbench
// Streams event timestamps into the core under random source and sink
// stalls, predicts window and peak counts with a queue-based model and
// checks every result beat. Covers edge spans, backward timestamps, run
// restarts, several window widths and a FIFO overflow run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import swmc_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_EVENTS  = 94;

  typedef struct packed {
    logic             ovf;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] cnt;
  } window_result_t;

  typedef enum logic {
    ROW_EVENT,
    ROW_WINDOW
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [TIME_W-1:0] value;
    logic             start;
    logic             fixed;
    window_result_t   res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [TIME_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // window model
  logic [TIME_W-1:0]    kept_times[$];
  logic [TIME_W-1:0]    win_len;
  int unsigned          best_run = 0;

  window_result_t       pending_results[$];
  window_result_t       pred_res;
  window_result_t       got_res;
  window_result_t       cur_fixed_res;
  logic                 cur_fixed;
  stim_row_t            dir_rows[$];
  logic [TIME_W-1:0]    stamp;

  int src_idle_pct;
  int sink_idle_pct;
  int sink_hold   = 0;
  int idle_cycles = 0;
  int errors      = 0;
  int n_events    = 0;
  int n_results   = 0;
  int n_overflow  = 0;
  int n_windows;
  int peak_seen   = 0;

  sliding_window_max_count_core #(
    .FIFO_DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic window_result_t count_event(input logic [TIME_W-1:0] t,
                                                 input logic start);
    window_result_t    r;
    logic [TIME_W-1:0] span;
    r = '0;
    if (start) begin
      kept_times.delete();
      best_run = 0;
    end
    while (kept_times.size() > 0) begin
      span = (t >= kept_times[0]) ? t - kept_times[0] : '0;
      if (span <= win_len) break;
      void'(kept_times.pop_front());
    end
    if (kept_times.size() >= DEPTH) begin
      void'(kept_times.pop_front());
      r.ovf = 1'b1;
    end
    kept_times.push_back(t);
    if (kept_times.size() > best_run) best_run = kept_times.size();
    r.cnt  = CNT_W'(kept_times.size());
    r.peak = CNT_W'(best_run);
    return r;
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 60;
    endcase
  endfunction

  function automatic stim_row_t ev_row(input logic [TIME_W-1:0] t, input logic start,
                                       input logic fixed, input int cnt, input int peak);
    stim_row_t r;
    r.kind     = ROW_EVENT;
    r.value    = t;
    r.start    = start;
    r.fixed    = fixed;
    r.res.ovf  = 1'b0;
    r.res.peak = CNT_W'(peak);
    r.res.cnt  = CNT_W'(cnt);
    return r;
  endfunction

  function automatic stim_row_t win_row(input logic [TIME_W-1:0] w);
    stim_row_t r;
    r       = ev_row(w, 1'b0, 1'b0, 0, 0);
    r.kind  = ROW_WINDOW;
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_event(input logic [TIME_W-1:0] t, input logic start,
                            input logic fixed, input window_result_t res);
    int gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_fixed     = fixed;
    cur_fixed_res = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] w);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    win_len     = w;
    n_windows++;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] w, input int n);
    logic [TIME_W-1:0] inc;
    logic [TIME_W-1:0] t;
    logic              start;
    int                sel;
    set_window(w);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        src_idle_pct  = idle_pct();
        sink_idle_pct = idle_pct();
      end
      start = 1'b0;
      sel   = $urandom_range(0, 19);
      if (sel == 0) begin
        start = 1'b1;
        case ($urandom_range(0, 2))
          0:       stamp = $urandom_range(0, 100);
          1:       stamp = 32'hFFFF_FFFF - $urandom_range(0, 100);
          default: stamp = $urandom;
        endcase
        t = stamp;
      end else if (sel == 1) begin
        t = $urandom;  // stray out-of-order stamp
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    inc = '0;
          2, 3, 4: inc = $urandom_range(0, (w >> 3) + 1);
          5:       inc = w;
          6:       inc = w + 1;
          7:       inc = $urandom_range(0, 3);
          8:       inc = $urandom;
          default: inc = $urandom_range(1, 16);
        endcase
        stamp = stamp + inc;
        t     = stamp;
      end
      send_event(t, start, 1'b0, '0);
    end
  endtask

  // result check, event prediction and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata[2*CNT_W:0];
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          pred_res = pending_results.pop_front();
          if (got_res.cnt !== pred_res.cnt) begin
            $display("%0t: window_count expected %0d got %0d", $time, pred_res.cnt,
                     got_res.cnt);
            errors++;
          end
          if (got_res.peak !== pred_res.peak) begin
            $display("%0t: max_count expected %0d got %0d", $time, pred_res.peak,
                     got_res.peak);
            errors++;
          end
          if (got_res.ovf !== pred_res.ovf) begin
            $display("%0t: overflow expected %0b got %0b", $time, pred_res.ovf,
                     got_res.ovf);
            errors++;
          end
        end
        n_results++;
        if (got_res.ovf === 1'b1) n_overflow++;
        if (got_res.cnt > peak_seen) peak_seen = got_res.cnt;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred_res = count_event(s_axis_tdata, s_axis_tuser);
        if (cur_fixed) pred_res = cur_fixed_res;
        pending_results.push_back(pred_res);
        n_events++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results pending", $time, idle_cycles,
                 pending_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        m_axis_tready <= 1'b0;
        sink_hold = pick_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cur_fixed     = 1'b0;
    cur_fixed_res = '0;
    win_len       = 32'd60;
    stamp         = '0;
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    n_windows     = 0;

    // window 60 after reset
    dir_rows.push_back(ev_row(32'd0, 1'b1, 1'b1, 1, 1));
    dir_rows.push_back(ev_row(32'd60, 1'b0, 1'b1, 2, 2));         // span equals window
    dir_rows.push_back(ev_row(32'd61, 1'b0, 1'b1, 2, 2));         // one past window
    dir_rows.push_back(ev_row(32'd200, 1'b0, 1'b1, 1, 2));
    dir_rows.push_back(ev_row(32'd100, 1'b0, 1'b1, 2, 2));        // backward stamp
    dir_rows.push_back(ev_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1, 2));
    dir_rows.push_back(ev_row(32'hFFFF_FFFF, 1'b0, 1'b1, 2, 2));
    dir_rows.push_back(ev_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1));
    dir_rows.push_back(ev_row(32'd0, 1'b0, 1'b1, 2, 2));          // below oldest
    dir_rows.push_back(win_row(32'd0));
    dir_rows.push_back(ev_row(32'd5, 1'b1, 1'b1, 1, 1));
    dir_rows.push_back(ev_row(32'd5, 1'b0, 1'b1, 2, 2));
    dir_rows.push_back(ev_row(32'd6, 1'b0, 1'b1, 1, 2));
    dir_rows.push_back(ev_row(32'd6, 1'b0, 1'b1, 2, 2));
    dir_rows.push_back(win_row(32'hFFFF_FFFF));
    dir_rows.push_back(ev_row(32'd0, 1'b1, 1'b1, 1, 1));
    dir_rows.push_back(ev_row(32'hFFFF_FFFF, 1'b0, 1'b1, 2, 2));
    dir_rows.push_back(ev_row(32'd12345, 1'b0, 1'b0, 0, 0));
    dir_rows.push_back(win_row(32'd60));
    dir_rows.push_back(ev_row(32'd1000, 1'b0, 1'b0, 0, 0));
    dir_rows.push_back(ev_row(32'd1000, 1'b1, 1'b1, 1, 1));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WINDOW)
        set_window(dir_rows[i].value);
      else
        send_event(dir_rows[i].value, dir_rows[i].start, dir_rows[i].fixed,
                   dir_rows[i].res);
    end

    stamp = 32'd1000;
    run_phase(32'd60, PHASE_EVENTS);
    run_phase(32'd0, PHASE_EVENTS);
    run_phase(32'd1, PHASE_EVENTS);
    run_phase(32'd10, PHASE_EVENTS);
    run_phase(32'd1000, PHASE_EVENTS);
    run_phase($urandom, PHASE_EVENTS);
    run_phase(32'hFFFF_FFFE, PHASE_EVENTS);
    run_phase(32'hFFFF_FFFF, PHASE_EVENTS);

    // fill past the FIFO depth, then age nearly everything out in one event
    set_window(32'hFFFF_FFFF);
    src_idle_pct  = 0;
    sink_idle_pct = 10;
    stamp = $urandom_range(0, 1000);
    send_event(stamp, 1'b1, 1'b0, '0);
    for (int i = 0; i < DEPTH + 40; i++) begin
      stamp = stamp + $urandom_range(0, 2);
      send_event(stamp, 1'b0, 1'b0, '0);
    end
    set_window(32'd3);
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    for (int i = 0; i < 6; i++) begin
      stamp = stamp + $urandom_range(1, 3);
      send_event(stamp, 1'b0, 1'b0, '0);
    end
    set_window(32'd60);
    send_event(stamp, 1'b1, 1'b0, '0);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Ran %0d events over %0d window settings, %0d results checked.", n_events,
             n_windows, n_results);
    $display("Largest window count %0d, %0d overflow results.", peak_seen, n_overflow);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
